// File: rtl/pcse_pkg.sv
// Shared codes, types and tables for the square-wave channel.
package pcse_pkg;

   localparam int FUNC_W  = 3;
   localparam int INDEX_W = 2;
   localparam int DATA_W  = 8;
   localparam int LEVEL_W = 4;
   localparam int PERIOD_W = 11;

   // Event codes
   localparam logic [FUNC_W-1:0] FUNC_REG_WRITE    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ENABLE_WRITE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_TIMER        = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_QUARTER      = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_HALF         = 3'd4;

   // Channel register indexes
   localparam logic [INDEX_W-1:0] REG_CONTROL     = 2'd0;
   localparam logic [INDEX_W-1:0] REG_SWEEP       = 2'd1;
   localparam logic [INDEX_W-1:0] REG_PERIOD_LOW  = 2'd2;
   localparam logic [INDEX_W-1:0] REG_PERIOD_HIGH = 2'd3;

   localparam logic [PERIOD_W-1:0] PERIOD_MIN = 11'd8;
   localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = 4'd15;

   // Length counter load values
   localparam logic [7:0] LENGTH_TABLE [32] = '{
      8'd10, 8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
      8'd160, 8'd8,  8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
      8'd12, 8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
      8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
   };

   // Duty sequences, bit n is step n
   localparam logic [7:0] DUTY_TABLE [4] = '{
      8'b0000_0010, 8'b0000_0110, 8'b0001_1110, 8'b1111_1001
   };

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] reg_index;
      logic [DATA_W-1:0]  write_data;
   } item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               length_active;
   } result_type;

endpackage

// File: rtl/pcse_if.sv
// Valid/ready channel interfaces for event words and result words.
interface pcse_req_if
   import pcse_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [INDEX_W-1:0] reg_index;
   logic [DATA_W-1:0]  write_data;

   modport source (output valid, func, reg_index, write_data, input ready);
   modport sink (input valid, func, reg_index, write_data, output ready);
endinterface

interface pcse_rsp_if
   import pcse_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level;
   logic               length_active;

   modport source (output valid, level, length_active, input ready);
   modport sink (input valid, level, length_active, output ready);
endinterface

// File: rtl/pulse_channel_sweep_envelope.sv
// Square-wave channel top level: event register, channel core, result register.
//
// One event word in, one result word out. Each event (register write, enable
// write, timer, quarter-frame or half-frame clock) is held in an input
// register, applied to the channel state as it leaves that register, and the
// resulting level and length status are captured in an output register. A
// new event is taken every cycle while the result side keeps up, so the
// sustained rate is one word per cycle; an event passes the input register
// and its result the output register. Backpressure on the result side stalls
// the input register and then the request side. The csr port sets the sweep
// negate mode and is to be written only while no event is in flight.
module pulse_channel_sweep_envelope
   import pcse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pcse_req_if.sink   req_ch,
   pcse_rsp_if.source rsp_ch,
   input  logic       csr_write_en,
   input  logic       csr_write_data
);

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff;
   result_type result_next;
   logic       ones_complement_ff;
   logic       out_free;
   logic       fire;
   logic       req_take;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign fire     = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_take = req_ch.valid && req_ch.ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         ones_complement_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            ones_complement_ff <= csr_write_data;
         end
      end
   end

   // Payload registers: load on acceptance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.func       <= req_ch.func;
         item_ff.reg_index  <= req_ch.reg_index;
         item_ff.write_data <= req_ch.write_data;
      end
      if (fire) begin
         result_ff <= result_next;
      end
   end

   pcse_core u_core (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .item            (item_ff),
      .ones_complement (ones_complement_ff),
      .result_next     (result_next)
   );

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.level         = result_ff.level;
   assign rsp_ch.length_active = result_ff.length_active;

endmodule

// File: rtl/pcse_core.sv
// Channel state: registers, envelope, sweep, length counter and level logic.
module pcse_core
   import pcse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  logic       ones_complement,
   output result_type result_next
);

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PERIOD_W-1:0] timer_count_ff, timer_count_in;
   logic [2:0]          duty_step_ff, duty_step_in;
   logic [1:0]          duty_select_ff, duty_select_in;
   logic                halt_loop_ff, halt_loop_in;
   logic                constant_volume_ff, constant_volume_in;
   logic [3:0]          volume_value_ff, volume_value_in;
   logic                sweep_on_ff, sweep_on_in;
   logic [3:0]          sweep_reload_ff, sweep_reload_in;
   logic                sweep_down_ff, sweep_down_in;
   logic [2:0]          sweep_amount_ff, sweep_amount_in;
   logic                sweep_restart_ff, sweep_restart_in;
   logic [3:0]          sweep_divider_ff, sweep_divider_in;
   logic [7:0]          length_count_ff, length_count_in;
   logic                envelope_restart_ff, envelope_restart_in;
   logic [3:0]          envelope_divider_ff, envelope_divider_in;
   logic [3:0]          envelope_level_ff, envelope_level_in;
   logic                channel_on_ff, channel_on_in;

   logic [PERIOD_W-1:0] sweep_change;
   logic [PERIOD_W+1:0] sweep_sum;
   logic                sweep_fits;
   logic [7:0]          duty_row;

   // Sweep target: subtract via inverted addend, carry in unless one's complement
   always_comb begin
      sweep_change = period_ff >> sweep_amount_ff;
      if (sweep_down_ff) begin
         sweep_sum = {2'b00, period_ff} + ~{2'b00, sweep_change}
                   + {{(PERIOD_W+1){1'b0}}, ~ones_complement};
      end else begin
         sweep_sum = {2'b00, period_ff} + {2'b00, sweep_change};
      end
      sweep_fits = !sweep_sum[PERIOD_W+1] && !sweep_sum[PERIOD_W]
                 && (sweep_sum[PERIOD_W-1:0] >= PERIOD_MIN);
   end

   always_comb begin
      period_in           = period_ff;
      timer_count_in      = timer_count_ff;
      duty_step_in        = duty_step_ff;
      duty_select_in      = duty_select_ff;
      halt_loop_in        = halt_loop_ff;
      constant_volume_in  = constant_volume_ff;
      volume_value_in     = volume_value_ff;
      sweep_on_in         = sweep_on_ff;
      sweep_reload_in     = sweep_reload_ff;
      sweep_down_in       = sweep_down_ff;
      sweep_amount_in     = sweep_amount_ff;
      sweep_restart_in    = sweep_restart_ff;
      sweep_divider_in    = sweep_divider_ff;
      length_count_in     = length_count_ff;
      envelope_restart_in = envelope_restart_ff;
      envelope_divider_in = envelope_divider_ff;
      envelope_level_in   = envelope_level_ff;
      channel_on_in       = channel_on_ff;

      case (item.func)
         FUNC_REG_WRITE: begin
            case (item.reg_index)
               REG_CONTROL: begin
                  duty_select_in     = item.write_data[7:6];
                  halt_loop_in       = item.write_data[5];
                  constant_volume_in = item.write_data[4];
                  volume_value_in    = item.write_data[3:0];
               end
               REG_SWEEP: begin
                  sweep_on_in      = item.write_data[7];
                  sweep_reload_in  = {1'b0, item.write_data[6:4]} + 4'd1;
                  sweep_down_in    = item.write_data[3];
                  sweep_amount_in  = item.write_data[2:0];
                  sweep_restart_in = 1'b1;
               end
               REG_PERIOD_LOW: begin
                  period_in = {period_ff[PERIOD_W-1:8], item.write_data};
               end
               default: begin
                  period_in = {item.write_data[2:0], period_ff[7:0]};
                  if (channel_on_ff) begin
                     length_count_in = LENGTH_TABLE[item.write_data[7:3]];
                  end
                  duty_step_in        = 3'd0;
                  envelope_restart_in = 1'b1;
               end
            endcase
         end
         FUNC_ENABLE_WRITE: begin
            channel_on_in = item.write_data[0];
            if (!item.write_data[0]) begin
               length_count_in = 8'd0;
            end
         end
         FUNC_TIMER: begin
            if (timer_count_ff == '0) begin
               timer_count_in = period_ff;
               duty_step_in   = duty_step_ff + 3'd1;
            end else begin
               timer_count_in = timer_count_ff - PERIOD_W'(1);
            end
         end
         FUNC_QUARTER: begin
            if (envelope_restart_ff) begin
               envelope_restart_in = 1'b0;
               envelope_level_in   = LEVEL_MAX;
               envelope_divider_in = volume_value_ff;
            end else if (envelope_divider_ff == 4'd0) begin
               envelope_divider_in = volume_value_ff;
               if (envelope_level_ff == 4'd0) begin
                  if (halt_loop_ff) begin
                     envelope_level_in = LEVEL_MAX;
                  end
               end else begin
                  envelope_level_in = envelope_level_ff - 4'd1;
               end
            end else begin
               envelope_divider_in = envelope_divider_ff - 4'd1;
            end
         end
         FUNC_HALF: begin
            if (!halt_loop_ff && length_count_ff != 8'd0) begin
               length_count_in = length_count_ff - 8'd1;
            end
            if (sweep_restart_ff) begin
               sweep_divider_in = sweep_reload_ff;
               sweep_restart_in = 1'b0;
            end else if (sweep_divider_ff != 4'd0) begin
               sweep_divider_in = sweep_divider_ff - 4'd1;
            end else begin
               sweep_divider_in = sweep_reload_ff;
               if (sweep_on_ff && sweep_amount_ff != 3'd0 && sweep_fits) begin
                  period_in = sweep_sum[PERIOD_W-1:0];
               end
            end
         end
         default: begin
            // unused event codes leave the state alone
         end
      endcase
   end

   // Level as seen after this word's update
   always_comb begin
      duty_row = DUTY_TABLE[duty_select_in];
      result_next.length_active = (length_count_in != 8'd0);
      if (!channel_on_in || length_count_in == 8'd0 || period_in < PERIOD_MIN
          || !duty_row[duty_step_in]) begin
         result_next.level = '0;
      end else if (constant_volume_in) begin
         result_next.level = volume_value_in;
      end else begin
         result_next.level = envelope_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff           <= '0;
         timer_count_ff      <= '0;
         duty_step_ff        <= '0;
         duty_select_ff      <= '0;
         halt_loop_ff        <= 1'b0;
         constant_volume_ff  <= 1'b0;
         volume_value_ff     <= '0;
         sweep_on_ff         <= 1'b0;
         sweep_reload_ff     <= '0;
         sweep_down_ff       <= 1'b0;
         sweep_amount_ff     <= '0;
         sweep_restart_ff    <= 1'b0;
         sweep_divider_ff    <= '0;
         length_count_ff     <= '0;
         envelope_restart_ff <= 1'b0;
         envelope_divider_ff <= '0;
         envelope_level_ff   <= '0;
         channel_on_ff       <= 1'b0;
      end else if (fire) begin
         period_ff           <= period_in;
         timer_count_ff      <= timer_count_in;
         duty_step_ff        <= duty_step_in;
         duty_select_ff      <= duty_select_in;
         halt_loop_ff        <= halt_loop_in;
         constant_volume_ff  <= constant_volume_in;
         volume_value_ff     <= volume_value_in;
         sweep_on_ff         <= sweep_on_in;
         sweep_reload_ff     <= sweep_reload_in;
         sweep_down_ff       <= sweep_down_in;
         sweep_amount_ff     <= sweep_amount_in;
         sweep_restart_ff    <= sweep_restart_in;
         sweep_divider_ff    <= sweep_divider_in;
         length_count_ff     <= length_count_in;
         envelope_restart_ff <= envelope_restart_in;
         envelope_divider_ff <= envelope_divider_in;
         envelope_level_ff   <= envelope_level_in;
         channel_on_ff       <= channel_on_in;
      end
   end

endmodule

// File: rtl/pcse_checker.sv
// Port-level checks for the square-wave channel, bound to the top level.
module pcse_port_checks
   import pcse_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [LEVEL_W-1:0] rsp_level,
   input logic               rsp_length_active
);

   // no result straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // a sounding channel always has a live length counter
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_level != '0 |-> rsp_length_active)
      else $error("nonzero level with length counter at zero");

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level)
                                  && $stable(rsp_length_active))
      else $error("stalled result word changed");

endmodule

bind pulse_channel_sweep_envelope pcse_port_checks u_pcse_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_level         (rsp_ch.level),
   .rsp_length_active (rsp_ch.length_active)
);

// File: verif/pcse_checker.sv
// Scoreboard for the square-wave channel: predicts every result word and compares it.
`timescale 1ns / 1ps
module pcse_checker
   import pcse_pkg::*;
(
   input  logic clock,
   input  logic reset,
   pcse_req_if  req_ch,
   pcse_rsp_if  rsp_ch,
   input  logic csr_write_en,
   input  logic csr_write_data,
   output int   fail_count,
   output int   outstanding
);

   localparam logic [7:0] LENGTH_LOAD [32] = '{
      8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
      8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
      8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
      8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
   };

   // Left-most bit is step 0
   localparam logic [0:7] WAVE_SHAPE [4] = '{
      8'b0100_0000, 8'b0110_0000, 8'b0111_1000, 8'b1001_1111
   };

   localparam int SWEEP_FLOOR = 8;
   localparam int PERIOD_SPAN = 2048;

   logic                ones_comp;
   logic [PERIOD_W-1:0] tone_period;
   logic [PERIOD_W-1:0] timer_left;
   logic [2:0]          wave_step;
   logic [1:0]          wave_sel;
   logic                loop_flag;
   logic                fixed_volume;
   logic [LEVEL_W-1:0]  volume;
   logic                sweep_en;
   logic [3:0]          sweep_reload;
   logic                sweep_neg;
   logic [2:0]          sweep_shift;
   logic                sweep_reload_due;
   logic [3:0]          sweep_div;
   logic [7:0]          length_left;
   logic                decay_reload_due;
   logic [3:0]          decay_div;
   logic [LEVEL_W-1:0]  decay_level;
   logic                chan_on;

   result_type level_status_q [$];
   int         words_seen;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic result_type step_channel(input item_type w);
      result_type r;
      logic [PERIOD_W-1:0] delta;
      int next_period;
      case (w.func)
         FUNC_REG_WRITE: begin
            case (w.reg_index)
               REG_CONTROL: begin
                  wave_sel     = w.write_data[7:6];
                  loop_flag    = w.write_data[5];
                  fixed_volume = w.write_data[4];
                  volume       = w.write_data[3:0];
               end
               REG_SWEEP: begin
                  sweep_en         = w.write_data[7];
                  sweep_reload     = {1'b0, w.write_data[6:4]} + 4'd1;
                  sweep_neg        = w.write_data[3];
                  sweep_shift      = w.write_data[2:0];
                  sweep_reload_due = 1'b1;
               end
               REG_PERIOD_LOW: tone_period[7:0] = w.write_data;
               default: begin
                  tone_period[10:8] = w.write_data[2:0];
                  // length loads only while the channel is on
                  if (chan_on)
                     length_left = LENGTH_LOAD[w.write_data[7:3]];
                  wave_step        = 3'd0;
                  decay_reload_due = 1'b1;
               end
            endcase
         end
         FUNC_ENABLE_WRITE: begin
            chan_on = w.write_data[0];
            if (!chan_on)
               length_left = 8'd0;
         end
         FUNC_TIMER: begin
            if (timer_left == '0) begin
               timer_left = tone_period;
               wave_step  = wave_step + 3'd1;
            end else begin
               timer_left = timer_left - 1'b1;
            end
         end
         FUNC_QUARTER: begin
            if (decay_reload_due) begin
               decay_reload_due = 1'b0;
               decay_level      = 4'd15;
               decay_div        = volume;
            end else if (decay_div == 4'd0) begin
               decay_div = volume;
               if (decay_level != 4'd0)
                  decay_level = decay_level - 4'd1;
               else if (loop_flag)
                  decay_level = 4'd15;
            end else begin
               decay_div = decay_div - 4'd1;
            end
         end
         FUNC_HALF: begin
            if (!loop_flag && length_left != 8'd0)
               length_left = length_left - 8'd1;
            if (sweep_reload_due) begin
               sweep_div        = sweep_reload;
               sweep_reload_due = 1'b0;
            end else if (sweep_div != 4'd0) begin
               sweep_div = sweep_div - 4'd1;
            end else begin
               sweep_div = sweep_reload;
               if (sweep_en && sweep_shift != 3'd0) begin
                  delta = tone_period >> sweep_shift;
                  // one's complement mode takes one more off a downward step
                  next_period = sweep_neg ? int'(tone_period) - int'(delta) - int'(ones_comp)
                                          : int'(tone_period) + int'(delta);
                  if (next_period >= SWEEP_FLOOR && next_period < PERIOD_SPAN)
                     tone_period = PERIOD_W'(next_period);
               end
            end
         end
         default: ;
      endcase
      r.length_active = (length_left != 8'd0);
      if (!chan_on || length_left == 8'd0 || int'(tone_period) < SWEEP_FLOOR
          || !WAVE_SHAPE[wave_sel][wave_step])
         r.level = '0;
      else
         r.level = fixed_volume ? volume : decay_level;
      return r;
   endfunction

   initial begin
      fail_count  = 0;
      outstanding = 0;
      words_seen  = 0;
   end

   always @(posedge clock) begin
      result_type want;
      item_type   taken;
      if (reset) begin
         ones_comp        = 1'b0;
         tone_period      = '0;
         timer_left       = '0;
         wave_step        = '0;
         wave_sel         = '0;
         loop_flag        = 1'b0;
         fixed_volume     = 1'b0;
         volume           = '0;
         sweep_en         = 1'b0;
         sweep_reload     = '0;
         sweep_neg        = 1'b0;
         sweep_shift      = '0;
         sweep_reload_due = 1'b0;
         sweep_div        = '0;
         length_left      = '0;
         decay_reload_due = 1'b0;
         decay_div        = '0;
         decay_level      = '0;
         chan_on          = 1'b0;
         level_status_q.delete();
      end else begin
         if (csr_write_en)
            ones_comp = csr_write_data;
         // compare before queuing: a word taken at this edge cannot be answered yet
         if (rsp_ch.valid && rsp_ch.ready) begin
            words_seen++;
            if (level_status_q.size() == 0) begin
               report_mismatch($sformatf("result word %0d with nothing outstanding", words_seen));
            end else begin
               want = level_status_q.pop_front();
               if (rsp_ch.level !== want.level)
                  report_mismatch($sformatf("result word %0d level %0d, predicted %0d",
                                            words_seen, rsp_ch.level, want.level));
               if (rsp_ch.length_active !== want.length_active)
                  report_mismatch($sformatf("result word %0d length_active %0b, predicted %0b",
                                            words_seen, rsp_ch.length_active,
                                            want.length_active));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            taken.func       = req_ch.func;
            taken.reg_index  = req_ch.reg_index;
            taken.write_data = req_ch.write_data;
            level_status_q = {level_status_q, step_channel(taken)};
         end
      end
      outstanding = level_status_q.size();
   end

endmodule

// File: verif/tb_pulse_channel_sweep_envelope.sv
// Testbench top for the square-wave channel: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_pulse_channel_sweep_envelope;
   import pcse_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

   localparam int  EVENT_TARGET   = 1450;
   localparam int  PHASES         = 4;
   localparam int  STEADY_TAIL    = 200;
   localparam int  SETTLE_CYCLES  = 6;
   localparam int  WATCHDOG_LIMIT = 2000;
   localparam bit  NEGATE_MODE [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0};

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic csr_write_data;
   int   fail_count;
   int   outstanding;
   int   events_sent = 0;
   int   gap_chance  = 20;
   int   idle_cycles = 0;
   bit   steady      = 1'b0;

   pcse_req_if req_ch ();
   pcse_rsp_if rsp_ch ();

   pulse_channel_sweep_envelope u_top (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   pcse_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_event(input logic [FUNC_W-1:0] f, input logic [INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] d);
      if (!steady && $urandom_range(0, 99) < gap_chance) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.func       <= f;
      req_ch.reg_index  <= idx;
      req_ch.write_data <= d;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      @(negedge clock);
      if (f <= FUNC_HALF)
         events_sent++;
   endtask

   // Drop valid and hold until every word has been answered and the pipe is empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Program the channel, then clock it
   task automatic play_note();
      int n;
      int roll;
      logic [DATA_W-1:0] d;
      case ($urandom_range(0, 3))
         0, 1: gap_chance = 0;
         2: gap_chance = 10;
         default: gap_chance = 35;
      endcase
      d    = DATA_W'($urandom);
      d[0] = ($urandom_range(0, 9) != 0);
      send_event(FUNC_ENABLE_WRITE, INDEX_W'($urandom), d);
      send_event(FUNC_REG_WRITE, REG_CONTROL, DATA_W'($urandom));
      d = DATA_W'($urandom);
      // short sweep divider half the time so the sweep actually fires
      if ($urandom_range(0, 1))
         d[6:5] = 2'b00;
      send_event(FUNC_REG_WRITE, REG_SWEEP, d);
      if ($urandom_range(0, 9) < 7)
         d = DATA_W'($urandom_range(8, 48));
      else
         d = DATA_W'($urandom);
      send_event(FUNC_REG_WRITE, REG_PERIOD_LOW, d);
      d = DATA_W'($urandom);
      if ($urandom_range(0, 9) < 7)
         d[2:0] = 3'b000;
      send_event(FUNC_REG_WRITE, REG_PERIOD_HIGH, d);
      n = $urandom_range(8, 48);
      repeat (n) begin
         roll = $urandom_range(0, 99);
         if (roll < 50)
            send_event(FUNC_TIMER, INDEX_W'($urandom), DATA_W'($urandom));
         else if (roll < 72)
            send_event(FUNC_QUARTER, INDEX_W'($urandom), DATA_W'($urandom));
         else if (roll < 94)
            send_event(FUNC_HALF, INDEX_W'($urandom), DATA_W'($urandom));
         else if (roll < 97)
            send_event(FUNC_REG_WRITE, INDEX_W'($urandom), DATA_W'($urandom));
         else
            send_event(FUNC_ENABLE_WRITE, INDEX_W'($urandom), DATA_W'($urandom));
      end
   endtask

   // Response side: random stall bursts in stretches of varying density
   initial begin
      int stall;
      int chance;
      int span;
      rsp_ch.ready = 1'b0;
      stall  = 0;
      chance = 10;
      span   = 0;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            case ($urandom_range(0, 3))
               0: chance = 0;
               1: chance = 5;
               2: chance = 15;
               default: chance = 40;
            endcase
            span = $urandom_range(20, 200);
         end else begin
            span--;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else if (!steady && $urandom_range(0, 99) < chance) begin
            rsp_ch.ready <= 1'b0;
            stall = $urandom_range(1, 14) - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int goal;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.func       = FUNC_REG_WRITE;
      req_ch.reg_index  = REG_CONTROL;
      req_ch.write_data = '0;
      csr_write_en      = 1'b0;
      csr_write_data    = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening: unused codes, length load while off, extremes, sweep edges
      send_event(FUNC_UNUSED_FIRST, REG_PERIOD_HIGH, 8'hFF);
      send_event(FUNC_UNUSED_LAST, REG_CONTROL, 8'h00);
      send_event(FUNC_ENABLE_WRITE, REG_PERIOD_HIGH, 8'hFE);
      send_event(FUNC_REG_WRITE, REG_PERIOD_HIGH, 8'hFF);
      send_event(FUNC_ENABLE_WRITE, REG_CONTROL, 8'h01);
      send_event(FUNC_REG_WRITE, REG_CONTROL, 8'hFF);
      send_event(FUNC_REG_WRITE, REG_SWEEP, 8'hFF);
      send_event(FUNC_REG_WRITE, REG_PERIOD_LOW, 8'hFF);
      send_event(FUNC_REG_WRITE, REG_PERIOD_HIGH, 8'h0F);
      send_event(FUNC_TIMER, REG_SWEEP, 8'hAA);
      send_event(FUNC_QUARTER, REG_PERIOD_LOW, 8'h55);
      send_event(FUNC_HALF, REG_PERIOD_HIGH, 8'hFF);
      send_event(FUNC_HALF, REG_CONTROL, 8'h00);
      send_event(FUNC_QUARTER, REG_CONTROL, 8'h00);
      send_event(FUNC_REG_WRITE, REG_CONTROL, 8'h00);
      send_event(FUNC_REG_WRITE, REG_PERIOD_LOW, 8'h05);
      send_event(FUNC_REG_WRITE, REG_PERIOD_HIGH, 8'h00);
      send_event(FUNC_TIMER, REG_CONTROL, 8'h00);
      send_event(FUNC_HALF, REG_CONTROL, 8'h00);
      send_event(FUNC_REG_WRITE, REG_SWEEP, 8'h00);
      send_event(FUNC_HALF, REG_CONTROL, 8'h00);
      send_event(FUNC_ENABLE_WRITE, REG_CONTROL, 8'h00);
      send_event(FUNC_QUARTER, REG_CONTROL, 8'h00);
      send_event(FUNC_TIMER, REG_CONTROL, 8'h00);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         csr_write_en   <= 1'b1;
         csr_write_data <= NEGATE_MODE[p];
         @(negedge clock);
         csr_write_en   <= 1'b0;
         @(negedge clock);
         goal = (p + 1) * EVENT_TARGET / PHASES;
         while (events_sent < goal) begin
            if (p == PHASES - 1 && events_sent >= EVENT_TARGET - STEADY_TAIL)
               steady = 1'b1;
            if ($urandom_range(0, 99) < 85) begin
               play_note();
            end else begin
               gap_chance = 20;
               repeat ($urandom_range(3, 12))
                  send_event(FUNC_W'($urandom), INDEX_W'($urandom), DATA_W'($urandom));
            end
         end
      end

      settle();
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
